// ===== rtl/core/mkd_pkg.sv =====
// Shared types, constants and helpers for the 3x3 key matrix debouncer.
// No dependencies; imported by mkd_event_drain and matrix_keypad_debouncer_unit.
package mkd_pkg;

   localparam int NUM_KEYS   = 9;
   localparam int KEY_W      = 4;
   localparam int KIDX_W     = $clog2(NUM_KEYS);
   localparam int TIME_W     = 32;
   localparam int DEB_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [NUM_KEYS-1:0] key_map_type;
   typedef logic [KEY_W-1:0]    key_code_type;
   typedef logic [KIDX_W-1:0]   key_idx_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [DEB_W-1:0]    deb_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_MS = CSR_IDX_W'(0),
      CSR_ACTIVE_LOW  = CSR_IDX_W'(1)
   } csr_index_type;

   // one evaluated scan handed to the event drain
   typedef struct packed {
      logic         load;
      key_map_type  pend;
      key_map_type  base_map;
      key_map_type  new_bits;
      key_code_type base_recent;
   } evt_load_type;

   function automatic key_code_type key_code_of(input key_idx_type k);
      key_code_of = KEY_W'(k) + KEY_W'(1);
   endfunction

endpackage

// ===== rtl/core/mkd_event_drain.sv =====
// Event buffer and result register: emits one key event per cycle while the output is not stalled, lowest key first.
// Depends on mkd_pkg.
module mkd_event_drain (
   input  logic                  clock,
   input  logic                  reset,
   input  mkd_pkg::evt_load_type ld,
   output logic                  buf_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mkd_pkg::key_code_type rsp_key_code,
   output logic                  rsp_is_press,
   output mkd_pkg::key_map_type  rsp_pressed_map,
   output mkd_pkg::key_code_type rsp_last_key,
   output logic                  rsp_last_of_run
);
   import mkd_pkg::*;

   key_map_type  pend_ff, pend_in;
   key_map_type  cur_map_ff, cur_map_in;
   key_map_type  new_bits_ff, new_bits_in;
   key_code_type cur_recent_ff, cur_recent_in;

   logic         rsp_valid_ff, rsp_valid_in;
   key_code_type rsp_key_ff, rsp_key_in;
   logic         rsp_press_ff, rsp_press_in;
   key_map_type  rsp_map_ff, rsp_map_in;
   key_code_type rsp_last_key_ff, rsp_last_key_in;
   logic         rsp_last_ff, rsp_last_in;

   key_idx_type  sel;
   key_map_type  pend_after;
   key_map_type  map_after;
   key_code_type recent_after;
   logic         drain;
   logic         sel_press;

   always_comb begin
      sel = '0;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            sel = KIDX_W'(k);
         end
      end
      sel_press       = new_bits_ff[sel];
      drain           = (pend_ff != '0) && (!rsp_valid_ff || !rsp_stall);
      pend_after      = pend_ff;
      pend_after[sel] = 1'b0;
      map_after       = cur_map_ff;
      map_after[sel]  = sel_press;
      recent_after    = sel_press ? key_code_of(sel) : cur_recent_ff;
      buf_free        = (pend_ff == '0) || (drain && (pend_after == '0));

      pend_in       = pend_ff;
      cur_map_in    = cur_map_ff;
      new_bits_in   = new_bits_ff;
      cur_recent_in = cur_recent_ff;
      if (drain) begin
         pend_in       = pend_after;
         cur_map_in    = map_after;
         cur_recent_in = recent_after;
      end
      if (ld.load) begin
         pend_in       = ld.pend;
         cur_map_in    = ld.base_map;
         new_bits_in   = ld.new_bits;
         cur_recent_in = ld.base_recent;
      end

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_key_in      = rsp_key_ff;
      rsp_press_in    = rsp_press_ff;
      rsp_map_in      = rsp_map_ff;
      rsp_last_key_in = rsp_last_key_ff;
      rsp_last_in     = rsp_last_ff;
      if (drain) begin
         rsp_valid_in    = 1'b1;
         rsp_key_in      = key_code_of(sel);
         rsp_press_in    = sel_press;
         rsp_map_in      = map_after;
         rsp_last_key_in = recent_after;
         rsp_last_in     = (pend_after == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_map_ff      <= cur_map_in;
      new_bits_ff     <= new_bits_in;
      cur_recent_ff   <= cur_recent_in;
      rsp_key_ff      <= rsp_key_in;
      rsp_press_ff    <= rsp_press_in;
      rsp_map_ff      <= rsp_map_in;
      rsp_last_key_ff <= rsp_last_key_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_code    = rsp_key_ff;
   assign rsp_is_press    = rsp_press_ff;
   assign rsp_pressed_map = rsp_map_ff;
   assign rsp_last_key    = rsp_last_key_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ld.load |-> buf_free)
      else $error("scan loaded over pending events");

   a_one_per_drain: assert property (@(posedge clock) disable iff (reset)
      drain && !ld.load |=> $countones(pend_ff) == $countones($past(pend_ff)) - 1)
      else $error("drain did not retire exactly one event");

   a_key_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_key_ff != '0) && (rsp_key_ff <= KEY_W'(NUM_KEYS)))
      else $error("event key out of range");

   a_press_sets_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_press_ff |-> rsp_last_key_ff == rsp_key_ff)
      else $error("press did not update last key");
endmodule

// ===== rtl/core/matrix_keypad_debouncer_unit.sv =====
// Top level of the 3x3 key matrix debouncer: scan register, per-key debounce state.
// A request passes through the scan register, the event buffer and the result register before its first event.
// Throughput: one scan per cycle while each scan yields at most one event and the output is not stalled;
// a scan with n events holds the event buffer until all are drained, one event per unstalled cycle.
// Reset: synchronous, clears debounced map, stamps and last key; debounce 50 ms, active low.
// Depends on mkd_pkg and mkd_event_drain.
module matrix_keypad_debouncer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mkd_pkg::key_map_type   req_raw_levels,
   input  mkd_pkg::time_type      req_time_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mkd_pkg::key_code_type  rsp_key_code,
   output logic                   rsp_is_press,
   output mkd_pkg::key_map_type   rsp_pressed_map,
   output mkd_pkg::key_code_type  rsp_last_key,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [mkd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mkd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mkd_pkg::*;

   deb_type      debounce_ff, debounce_in;
   logic         active_low_ff, active_low_in;

   logic         in_valid_ff, in_valid_in;
   key_map_type  raw_ff, raw_in;
   time_type     time_ff, time_in;

   key_map_type  map_ff, map_in;
   time_type     stamp_ff [NUM_KEYS];
   time_type     stamp_in [NUM_KEYS];
   key_code_type recent_ff, recent_in;

   key_map_type  pressed;
   key_map_type  acc;
   key_code_type recent_next;
   time_type     elapsed;
   logic         buf_free;
   logic         move;
   evt_load_type ld;

   assign csr_ready = 1'b1;
   assign move      = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !move;

   always_comb begin
      debounce_in   = debounce_ff;
      active_low_in = active_low_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS: debounce_in   = DEB_W'(csr_wdata);
            CSR_ACTIVE_LOW:  active_low_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      elapsed     = '0;
      recent_next = recent_ff;
      for (int k = 0; k < NUM_KEYS; k++) begin
         pressed[k] = raw_ff[k] ^ active_low_ff;
         elapsed    = time_ff - stamp_ff[k];
         acc[k]     = (pressed[k] != map_ff[k]) && (elapsed >= TIME_W'(debounce_ff));
         if (acc[k] && pressed[k]) begin
            recent_next = key_code_of(KIDX_W'(k));
         end
      end

      in_valid_in = in_valid_ff && !move;
      raw_in      = raw_ff;
      time_in     = time_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         raw_in      = req_raw_levels;
         time_in     = req_time_ms;
      end

      map_in    = map_ff;
      recent_in = recent_ff;
      for (int k = 0; k < NUM_KEYS; k++) begin
         stamp_in[k] = stamp_ff[k];
      end
      if (move) begin
         map_in    = map_ff ^ acc;
         recent_in = recent_next;
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (acc[k]) begin
               stamp_in[k] = time_ff;
            end
         end
      end

      ld.load        = move && (acc != '0);
      ld.pend        = acc;
      ld.base_map    = map_ff;
      ld.new_bits    = pressed;
      ld.base_recent = recent_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEB_W'(50);
         active_low_ff <= 1'b1;
         in_valid_ff   <= 1'b0;
         map_ff        <= '0;
         recent_ff     <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            stamp_ff[k] <= '0;
         end
      end else begin
         debounce_ff   <= debounce_in;
         active_low_ff <= active_low_in;
         in_valid_ff   <= in_valid_in;
         map_ff        <= map_in;
         recent_ff     <= recent_in;
         for (int k = 0; k < NUM_KEYS; k++) begin
            stamp_ff[k] <= stamp_in[k];
         end
      end
      raw_ff  <= raw_in;
      time_ff <= time_in;
   end

   mkd_event_drain u_drain (
      .clock           (clock),
      .reset           (reset),
      .ld              (ld),
      .buf_free        (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_code    (rsp_key_code),
      .rsp_is_press    (rsp_is_press),
      .rsp_pressed_map (rsp_pressed_map),
      .rsp_last_key    (rsp_last_key),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_stall_needs_scan: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled with empty scan register");

   a_map_holds: assert property (@(posedge clock) disable iff (reset)
      !move |=> map_ff == $past(map_ff))
      else $error("debounced map changed without a scan");

   a_recent_on_press: assert property (@(posedge clock) disable iff (reset)
      move && ((acc & pressed) == '0) |=> recent_ff == $past(recent_ff))
      else $error("last key changed without a press");
endmodule
